// ----- rtl/fptm_pkg.sv -----
package fptm_pkg;

  localparam int unsigned VA_W              = 48;
  localparam int unsigned PA_W              = 52;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned PAGE_SHIFT        = 12;
  localparam int unsigned PFN_W             = PA_W - PAGE_SHIFT;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ENTRIES_PER_TABLE = 512;

  // present | writable | user for a freshly linked table
  localparam logic [2:0] PTR_FLAGS = 3'b111;
  localparam logic [1:0] LVL_LEAF  = 2'd3;

  typedef enum logic [1:0] {
    REQ_MAP       = 2'd0,
    REQ_UNMAP     = 2'd1,
    REQ_TRANSLATE = 2'd2,
    REQ_NOP       = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NOT_MAPPED = 2'd1,
    STS_EXHAUSTED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    WS_CLEAR,
    WS_IDLE,
    WS_WALK
  } walk_state_e;

  // Nine-bit table index for one level: root, pointer, directory, leaf.
  function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                input logic [1:0] lvl);
    logic [IDX_W-1:0] idx;
    case (lvl)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
    return idx;
  endfunction

endpackage

// ----- rtl/fptm_if.sv -----
interface fptm_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [fptm_pkg::VA_W-1:0]    virt_addr;
  logic [fptm_pkg::PA_W-1:0]    phys_addr;
  logic [fptm_pkg::ENTRY_W-1:0] pte_flags;

  modport source(output valid, req_type, virt_addr, phys_addr, pte_flags, input ready);
  modport sink(input valid, req_type, virt_addr, phys_addr, pte_flags, output ready);
endinterface

interface fptm_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [fptm_pkg::PA_W-1:0] phys_result;

  modport source(output valid, status, phys_result, input ready);
  modport sink(input valid, status, phys_result, output ready);
endinterface

interface fptm_cfg_if;
  logic                     valid;
  logic                     ready;
  logic [fptm_pkg::PA_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ----- rtl/fptm_store.sv -----
module fptm_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [fptm_pkg::ENTRY_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [fptm_pkg::ENTRY_W-1:0] rdata_o
);

  logic [fptm_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [fptm_pkg::ENTRY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fptm_walker.sv -----
module fptm_walker #(
  parameter int unsigned TABLE_FRAMES = 16,
  parameter int unsigned FW           = 4,
  parameter int unsigned AW           = 13
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fptm_req_if.sink                     req_i,
  fptm_rsp_if.source                   rsp_o,
  input  logic [fptm_pkg::PA_W-1:0]    table_base_i,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_waddr_o,
  output logic [fptm_pkg::ENTRY_W-1:0] mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AW-1:0]                mem_raddr_o,
  input  logic [fptm_pkg::ENTRY_W-1:0] mem_rdata_i
);

  localparam int unsigned NW    = $clog2(TABLE_FRAMES + 1);
  localparam int unsigned DEPTH = TABLE_FRAMES * fptm_pkg::ENTRIES_PER_TABLE;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  fptm_pkg::walk_state_e state_q, state_d;

  logic [1:0]                   lvl_q;
  logic [AW-1:0]                clr_q;
  logic [NW-1:0]                nff_q;
  logic [AW-1:0]                slot_q;
  logic [1:0]                   type_q;
  logic [fptm_pkg::VA_W-1:0]    va_q;
  logic [fptm_pkg::PA_W-1:0]    pa_q;
  logic [fptm_pkg::ENTRY_W-1:0] flags_q;
  logic                         rsp_valid_q;
  logic [1:0]                   rsp_status_q;
  logic [fptm_pkg::PA_W-1:0]    rsp_result_q;

  logic                         accept;
  logic                         out_free;
  logic                         present;
  logic [fptm_pkg::PFN_W-1:0]   diff;
  logic                         in_range;
  logic                         want_finish;
  logic                         done;
  logic                         alloc;
  logic                         advance;
  logic                         leaf_we;
  logic [fptm_pkg::ENTRY_W-1:0] leaf_wdata;
  logic [FW-1:0]                next_frame;
  logic [1:0]                   fin_status;
  logic [fptm_pkg::PA_W-1:0]    fin_result;
  logic [fptm_pkg::PFN_W-1:0]   alloc_pfn;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_valid_q || rsp_o.ready;
  assign present  = mem_rdata_i[0];
  assign diff     = mem_rdata_i[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT]
                  - table_base_i[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT];
  assign in_range = diff < fptm_pkg::PFN_W'(TABLE_FRAMES);
  assign alloc_pfn = table_base_i[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT]
                   + fptm_pkg::PFN_W'(nff_q);

  // Evaluate the entry read last cycle and decide the step.
  always_comb begin
    want_finish = 1'b0;
    alloc       = 1'b0;
    advance     = 1'b0;
    leaf_we     = 1'b0;
    leaf_wdata  = '0;
    next_frame  = '0;
    fin_status  = fptm_pkg::STS_OK;
    fin_result  = '0;
    if (state_q == fptm_pkg::WS_WALK) begin
      if (type_q == fptm_pkg::REQ_NOP) begin
        want_finish = 1'b1;
      end else if (lvl_q != fptm_pkg::LVL_LEAF) begin
        if (present) begin
          if (in_range) begin
            advance    = 1'b1;
            next_frame = diff[FW-1:0];
          end else begin
            want_finish = 1'b1;
            fin_status  = fptm_pkg::STS_NOT_MAPPED;
          end
        end else if (type_q != fptm_pkg::REQ_MAP) begin
          want_finish = 1'b1;
          fin_status  = fptm_pkg::STS_NOT_MAPPED;
        end else if (nff_q >= NW'(TABLE_FRAMES)) begin
          want_finish = 1'b1;
          fin_status  = fptm_pkg::STS_EXHAUSTED;
        end else begin
          alloc      = 1'b1;
          advance    = 1'b1;
          next_frame = nff_q[FW-1:0];
        end
      end else begin
        want_finish = 1'b1;
        case (type_q)
          fptm_pkg::REQ_MAP: begin
            leaf_we    = 1'b1;
            leaf_wdata = {12'b0, pa_q[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT],
                          12'b0} | flags_q | 64'd1;
          end
          fptm_pkg::REQ_UNMAP: begin
            if (present) begin
              leaf_we = 1'b1;
            end else begin
              fin_status = fptm_pkg::STS_NOT_MAPPED;
            end
          end
          fptm_pkg::REQ_TRANSLATE: begin
            if (present) begin
              fin_result = {mem_rdata_i[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT],
                            va_q[fptm_pkg::PAGE_SHIFT-1:0]};
            end else begin
              fin_status = fptm_pkg::STS_NOT_MAPPED;
            end
          end
          default: begin
            fin_status = fptm_pkg::STS_OK;
          end
        endcase
      end
    end
  end

  assign done = want_finish && out_free;

  // Memory port drive: clear sweep, root read on accept, walk steps.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = slot_q;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = {next_frame, fptm_pkg::va_index(va_q, lvl_q + 2'd1)};
    req_i.ready = 1'b0;
    case (state_q)
      fptm_pkg::WS_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
      end
      fptm_pkg::WS_IDLE: begin
        req_i.ready = 1'b1;
        mem_re_o    = req_i.valid;
        mem_raddr_o = {{FW{1'b0}}, fptm_pkg::va_index(req_i.virt_addr, 2'd0)};
      end
      fptm_pkg::WS_WALK: begin
        mem_re_o = advance;
        if (alloc) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = {12'b0, alloc_pfn, 9'b0, fptm_pkg::PTR_FLAGS};
        end else if (leaf_we && out_free) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = leaf_wdata;
        end
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      fptm_pkg::WS_CLEAR: begin
        if (clr_q == LAST_ADDR) begin
          state_d = fptm_pkg::WS_IDLE;
        end
      end
      fptm_pkg::WS_IDLE: begin
        if (accept) begin
          state_d = fptm_pkg::WS_WALK;
        end
      end
      fptm_pkg::WS_WALK: begin
        if (done) begin
          state_d = fptm_pkg::WS_IDLE;
        end
      end
      default: begin
        state_d = fptm_pkg::WS_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fptm_pkg::WS_CLEAR;
      clr_q       <= '0;
      nff_q       <= NW'(1);
      lvl_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == fptm_pkg::WS_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (alloc) begin
        nff_q <= nff_q + NW'(1);
      end
      if (accept) begin
        lvl_q <= '0;
      end else if (advance) begin
        lvl_q <= lvl_q + 2'd1;
      end
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re_o) begin
      slot_q <= mem_raddr_o;
    end
    if (accept) begin
      type_q  <= req_i.req_type;
      va_q    <= req_i.virt_addr;
      pa_q    <= req_i.phys_addr;
      flags_q <= req_i.pte_flags;
    end
    if (done) begin
      rsp_status_q <= fin_status;
      rsp_result_q <= fin_result;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.phys_result = rsp_result_q;

  a_nff_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nff_q <= NW'(TABLE_FRAMES))
    else $error("free-frame counter beyond table frames");

  a_nff_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nff_q != $past(nff_q)) |-> (nff_q == $past(nff_q) + NW'(1)))
    else $error("free-frame counter moved by more than one");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fptm_pkg::WS_IDLE) |-> !mem_we_o)
    else $error("table store written while idle");

  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == fptm_pkg::WS_WALK && lvl_q == 2'd0))
    else $error("walk did not start at the root after accept");

endmodule

// ----- rtl/four_level_page_table_manager_core.sv -----
// Four-level page table manager.
// req_i carries one request (map, unmap, translate, no-op) with its virtual
// address, physical page and leaf flags; rsp_o returns status and the
// translated address; cfg_i writes table_base, the physical address of
// store frame zero, and is always ready. Write it only while idle.
// Walk: an accepted request reads its root, pointer, directory and leaf
// entries in turn, one table store access per cycle through the single
// read port, and its response is registered after the leaf step; early
// exits (missing table, stray pointer, no-op type) respond sooner. The
// next request is taken the cycle after the response is registered, so
// requests do not overlap: throughput is set by the four dependent reads
// and the idle cycle that takes the next request.
// Reset: the table store is swept to zero, one entry a cycle, through
// all TABLE_FRAMES*512 entries (8192 by default); req_i.ready stays low then.
// Stall: a waiting response is held in the output register; a request in
// flight holds at its final step, without writing, until the slot frees.
module four_level_page_table_manager_core #(
  parameter int unsigned TABLE_FRAMES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fptm_req_if.sink   req_i,
  fptm_rsp_if.source rsp_o,
  fptm_cfg_if.sink   cfg_i
);

  // frame index width and store address width (frame, nine-bit index)
  localparam int unsigned FW    = $clog2(TABLE_FRAMES);
  localparam int unsigned AW    = FW + fptm_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_FRAMES * fptm_pkg::ENTRIES_PER_TABLE;

  logic [fptm_pkg::PA_W-1:0]    table_base_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [fptm_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [fptm_pkg::ENTRY_W-1:0] mem_rdata;

  // Take the base register on every write; low 12 bits are dropped
  // where the walker uses it.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_base_q <= '0;
    end else if (cfg_i.valid) begin
      table_base_q <= cfg_i.data;
    end
  end

  // Sequencer: clear sweep, walk, allocate, leaf update, response slot.
  fptm_walker #(
    .TABLE_FRAMES(TABLE_FRAMES),
    .FW          (FW),
    .AW          (AW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .table_base_i(table_base_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // Table store: one write and one registered read per cycle.
  fptm_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

// ----- test/tb.sv -----
module tb;

  localparam int unsigned TABLE_FRAMES = 16;
  localparam int unsigned STORE_DEPTH  = TABLE_FRAMES * fptm_pkg::ENTRIES_PER_TABLE;
  // address bits 51..12 of a table entry or a physical address
  localparam logic [fptm_pkg::PA_W-1:0] PAGE_NUM_MASK = 52'hF_FFFF_FFFF_F000;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  // one response as the block should return it
  typedef struct packed {
    fptm_pkg::status_e             st;
    logic [fptm_pkg::PA_W-1:0]     res;
  } outcome_t;

  // one row of the directed table; a config row carries table_base in pa
  typedef struct packed {
    row_kind_e                     kind;
    fptm_pkg::req_type_e           rtype;
    logic [fptm_pkg::VA_W-1:0]     va;
    logic [fptm_pkg::PA_W-1:0]     pa;
    logic [fptm_pkg::ENTRY_W-1:0]  flags;
    logic                          typed;
    fptm_pkg::status_e             st;
    logic [fptm_pkg::PA_W-1:0]     res;
  } dir_row_t;

  logic clk;
  logic rst_n;

  fptm_req_if req_if();
  fptm_rsp_if rsp_if();
  fptm_cfg_if cfg_if();

  four_level_page_table_manager_core #(
    .TABLE_FRAMES(TABLE_FRAMES)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the table store, the frame allocator and table_base.
  logic [fptm_pkg::ENTRY_W-1:0] mirror [0:STORE_DEPTH-1];
  int unsigned                  mirror_next;
  logic [fptm_pkg::PA_W-1:0]    mirror_base;

  // Responses owed by the block, oldest first.
  outcome_t outcome_q[$];
  dir_row_t dir_rows[$];

  int unsigned n_bad;
  // Odds of an idle burst per cycle, as 1 in gap_odds; zero turns idling off.
  int unsigned gap_odds;
  int unsigned rdy_hold;
  logic [8:0]  leaf_pick[4];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------
  // Shadow of the table walk
  // ---------------------------------------------------------------------

  // Physical address of store frame f under the current table_base.
  function automatic logic [fptm_pkg::PA_W-1:0] frame_base_addr(int unsigned f);
    return ((mirror_base & PAGE_NUM_MASK)
            + (fptm_pkg::PA_W'(f) << fptm_pkg::PAGE_SHIFT)) & PAGE_NUM_MASK;
  endfunction

  // Map a pointer entry back to a store frame; fail on a stray pointer.
  function automatic bit entry_to_frame(logic [fptm_pkg::ENTRY_W-1:0] e,
                                        output int unsigned f);
    logic [fptm_pkg::PA_W-1:0] diff;
    diff = (e[fptm_pkg::PA_W-1:0] & PAGE_NUM_MASK) - (mirror_base & PAGE_NUM_MASK);
    f = 0;
    if (diff[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT] >= TABLE_FRAMES) return 1'b0;
    f = int'(diff[fptm_pkg::PA_W-1:fptm_pkg::PAGE_SHIFT]);
    return 1'b1;
  endfunction

  // Walk root, pointer and directory levels down to the leaf slot.
  // With grow set, link a fresh zeroed frame wherever a table is missing.
  function automatic fptm_pkg::status_e locate_leaf(logic [fptm_pkg::VA_W-1:0] va,
                                                    bit grow,
                                                    output int unsigned leaf);
    int unsigned                  frame;
    int unsigned                  s;
    logic [fptm_pkg::IDX_W-1:0]   idx;
    logic [fptm_pkg::ENTRY_W-1:0] e;
    frame = 0;
    leaf  = 0;
    for (int lvl = 0; lvl < 3; lvl++) begin
      idx = va[39 - 9 * lvl +: fptm_pkg::IDX_W];
      s   = frame * fptm_pkg::ENTRIES_PER_TABLE + idx;
      e   = mirror[s];
      if (!e[0]) begin
        if (!grow) return fptm_pkg::STS_NOT_MAPPED;
        if (mirror_next >= TABLE_FRAMES) return fptm_pkg::STS_EXHAUSTED;
        e = {12'b0, frame_base_addr(mirror_next)} | {61'b0, fptm_pkg::PTR_FLAGS};
        mirror[s] = e;
        mirror_next++;
      end
      if (!entry_to_frame(e, frame)) return fptm_pkg::STS_NOT_MAPPED;
    end
    leaf = frame * fptm_pkg::ENTRIES_PER_TABLE + va[20:12];
    return fptm_pkg::STS_OK;
  endfunction

  // Apply one request to the shadow state and return its response.
  function automatic outcome_t apply_request(fptm_pkg::req_type_e rt,
                                             logic [fptm_pkg::VA_W-1:0] va,
                                             logic [fptm_pkg::PA_W-1:0] pa,
                                             logic [fptm_pkg::ENTRY_W-1:0] flags);
    outcome_t          o;
    fptm_pkg::status_e st;
    int unsigned       leaf;
    o.st  = fptm_pkg::STS_OK;
    o.res = '0;
    case (rt)
      fptm_pkg::REQ_MAP: begin
        st = locate_leaf(va, 1'b1, leaf);
        if (st == fptm_pkg::STS_OK)
          mirror[leaf] = {12'b0, pa & PAGE_NUM_MASK} | flags | 64'd1;
        o.st = st;
      end
      fptm_pkg::REQ_UNMAP: begin
        st = locate_leaf(va, 1'b0, leaf);
        if (st == fptm_pkg::STS_OK && mirror[leaf][0]) mirror[leaf] = '0;
        else o.st = fptm_pkg::STS_NOT_MAPPED;
      end
      fptm_pkg::REQ_TRANSLATE: begin
        st = locate_leaf(va, 1'b0, leaf);
        if (st == fptm_pkg::STS_OK && mirror[leaf][0])
          o.res = (mirror[leaf][fptm_pkg::PA_W-1:0] & PAGE_NUM_MASK)
                | fptm_pkg::PA_W'(va[11:0]);
        else o.st = fptm_pkg::STS_NOT_MAPPED;
      end
      default: ;
    endcase
    return o;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------

  // Present one request, starting at a falling edge. Hold it until taken,
  // then log what the block owes for it. Return at the next falling edge
  // with valid still high, so back-to-back requests never glitch valid.
  task automatic issue_req(fptm_pkg::req_type_e rt, logic [fptm_pkg::VA_W-1:0] va,
                           logic [fptm_pkg::PA_W-1:0] pa,
                           logic [fptm_pkg::ENTRY_W-1:0] flags, bit typed,
                           outcome_t typed_out);
    outcome_t got;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= rt;
    req_if.virt_addr <= va;
    req_if.phys_addr <= pa;
    req_if.pte_flags <= flags;
    do @(posedge clk); while (!req_if.ready);
    got = apply_request(rt, va, pa, flags);
    // a typed row overrides the shadow's answer, the shadow still advances
    outcome_q.push_back(typed ? typed_out : got);
    @(negedge clk);
  endtask

  // Rewrite table_base. Drain every owed response first so the block is idle.
  task automatic write_base(logic [fptm_pkg::PA_W-1:0] b);
    req_if.valid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= b;
    do @(posedge clk); while (!cfg_if.ready);
    mirror_base = b;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Random requests. Most land on the eight table paths built by the
  // directed part (every level index 0 or 511) and on a few leaf slots,
  // so translates and unmaps keep hitting live leaves; the rest are
  // noise addresses that walk off into missing or exhausted tables.
  task automatic run_random(int unsigned n);
    fptm_pkg::req_type_e          rt;
    logic [fptm_pkg::VA_W-1:0]    va;
    logic [fptm_pkg::PA_W-1:0]    pa;
    logic [fptm_pkg::ENTRY_W-1:0] flags;
    logic [8:0]                   lf;
    int unsigned                  pick;
    for (int unsigned k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 30)      rt = fptm_pkg::REQ_MAP;
      else if (pick < 50) rt = fptm_pkg::REQ_UNMAP;
      else if (pick < 95) rt = fptm_pkg::REQ_TRANSLATE;
      else                rt = fptm_pkg::REQ_NOP;
      if ($urandom_range(0, 9) == 0) begin
        va = {16'($urandom), $urandom};
      end else begin
        if ($urandom_range(0, 3) != 0) lf = leaf_pick[$urandom_range(0, 3)];
        else lf = 9'($urandom_range(0, 511));
        va = {($urandom_range(0, 1) ? 9'h1FF : 9'h000),
              ($urandom_range(0, 1) ? 9'h1FF : 9'h000),
              ($urandom_range(0, 1) ? 9'h1FF : 9'h000),
              lf, 12'($urandom_range(0, 4095))};
      end
      pa = {20'($urandom), $urandom};
      if ($urandom_range(0, 3) == 0) flags = {$urandom, $urandom};
      else flags = 64'($urandom_range(0, 4095));
      issue_req(rt, va, pa, flags, 1'b0, '0);
    end
    req_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Response side
  // ---------------------------------------------------------------------

  // Stall the response channel in random bursts.
  always @(negedge clk) begin
    if (rdy_hold != 0) begin
      rsp_if.ready <= 1'b0;
      rdy_hold <= rdy_hold - 1;
    end else if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      rsp_if.ready <= 1'b0;
      rdy_hold <= $urandom_range(1, 15) - 1;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // Compare each accepted response with the oldest owed one.
  always @(posedge clk) begin : rsp_check
    outcome_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (outcome_q.size() == 0) begin
        if (n_bad < 10)
          $display("tb: unexpected response status=%0d phys=%h",
                   rsp_if.status, rsp_if.phys_result);
        n_bad++;
      end else begin
        want = outcome_q.pop_front();
        if (want.st !== rsp_if.status || want.res !== rsp_if.phys_result) begin
          if (n_bad < 10)
            $display("tb: mismatch status exp=%0d got=%0d phys exp=%h got=%h",
                     want.st, rsp_if.status, want.res, rsp_if.phys_result);
          n_bad++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------

  initial begin
    foreach (mirror[i]) mirror[i] = '0;
    mirror_next = 1;
    mirror_base = '0;
    n_bad       = 0;
    gap_odds    = 4;
    rdy_hold    = 0;

    // drive every input to a known value before reset ends
    rst_n            = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = fptm_pkg::REQ_NOP;
    req_if.virt_addr = '0;
    req_if.phys_addr = '0;
    req_if.pte_flags = '0;
    rsp_if.ready     = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.data      = '0;

    leaf_pick[0] = 9'h000;
    leaf_pick[1] = 9'h1FF;
    leaf_pick[2] = 9'($urandom_range(1, 510));
    leaf_pick[3] = 9'($urandom_range(1, 510));

    // Directed table. The maps fill all eight extreme-index paths, which
    // takes fourteen of the fifteen free frames; the map that follows at
    // root index one links the last frame and then runs dry, and the frame
    // it linked stays in place. A far table_base then turns every pointer
    // stray, and writing zero back restores the walk.
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'h0, 52'h0, 64'h0,
                         1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_UNMAP, 48'h0, 52'h0, 64'h0,
                         1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_NOP, 48'hFFFF_FFFF_FFFF,
                         52'hF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                         1'b1, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0, 52'hF_FFFF_FFFF_FFFF, 64'h0,
                         1'b1, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'h0000_0000_0FFF, 52'h0,
                         64'h0, 1'b1, fptm_pkg::STS_OK, 52'hF_FFFF_FFFF_FFFF});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'hFFFF_FFFF_FFFF, 52'h0,
                         64'hFFFF_FFFF_FFFF_FFFF, 1'b1, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'hFFFF_FFFF_F000, 52'h0,
                         64'h0, 1'b1, fptm_pkg::STS_OK, 52'hF_FFFF_FFFF_F000});
    // map over a present leaf
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0, 52'h0_1234_5678_9000, 64'h6,
                         1'b1, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'h0000_0000_0ABC, 52'h0,
                         64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_UNMAP, 48'h0, 52'h0, 64'h0,
                         1'b1, fptm_pkg::STS_OK, 52'h0});
    // unmap and translate of a leaf that is no longer present
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_UNMAP, 48'h0, 52'h0, 64'h0,
                         1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'h0, 52'h0, 64'h0,
                         1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0000_3FE0_0000,
                         52'h0_0000_0001_1000, 64'h2, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h007F_C000_0000,
                         52'h0_0000_0002_2000, 64'h4, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h007F_FFE0_0000,
                         52'h0_0000_0003_3000, 64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'hFF80_0000_0000,
                         52'h0_0000_0004_4000, 64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'hFF80_3FE0_0000,
                         52'h0_0000_0005_5000, 64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'hFFFF_C000_0000,
                         52'h0_0000_0006_6000, 64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});
    // missing root entry, then frames run out part way down the walk
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'h0080_0000_0000, 52'h0,
                         64'h0, 1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0080_0000_0000,
                         52'h0_0000_0007_7000, 64'h0, 1'b1, fptm_pkg::STS_EXHAUSTED,
                         52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0080_4000_0000,
                         52'h0_0000_0008_8000, 64'h0, 1'b1, fptm_pkg::STS_EXHAUSTED,
                         52'h0});
    // stray pointers under a far table_base
    dir_rows.push_back('{ROW_CFG, fptm_pkg::REQ_NOP, 48'h0, 52'h0_0ABC_DE00_0000, 64'h0,
                         1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0,
                         64'h0, 1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_MAP, 48'h0, 52'h0_0000_0009_9000, 64'h0,
                         1'b1, fptm_pkg::STS_NOT_MAPPED, 52'h0});
    dir_rows.push_back('{ROW_CFG, fptm_pkg::REQ_NOP, 48'h0, 52'h0, 64'h0,
                         1'b0, fptm_pkg::STS_OK, 52'h0});
    dir_rows.push_back('{ROW_REQ, fptm_pkg::REQ_TRANSLATE, 48'hFFFF_FFFF_F123, 52'h0,
                         64'h0, 1'b0, fptm_pkg::STS_OK, 52'h0});

    // hold reset, release at a falling edge
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // walk the directed table; the store clear after reset holds off the
    // first request through ready alone
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_base(dir_rows[i].pa);
      else
        issue_req(dir_rows[i].rtype, dir_rows[i].va, dir_rows[i].pa, dir_rows[i].flags,
                  dir_rows[i].typed, '{dir_rows[i].st, dir_rows[i].res});
    end
    req_if.valid <= 1'b0;

    // random phases under several table_base settings
    run_random(450);

    // all-ones base: old pointers now resolve one frame further on, the
    // last one turns stray, and frame addresses wrap around
    gap_odds = 3;
    write_base(52'hF_FFFF_FFFF_FFFF);
    run_random(150);

    // arbitrary base, no idling on either side
    gap_odds = 0;
    write_base({20'($urandom), $urandom});
    run_random(100);

    // base two frames up: low frames turn stray, the rest shift down
    gap_odds = 6;
    write_base(52'h0_0000_0000_2000);
    run_random(150);

    // back to the base the tables were built with; finish without idling
    gap_odds = 4;
    write_base(52'h0);
    run_random(500);
    gap_odds = 0;
    run_random(200);

    // drain, then leave room for any stray response
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (n_bad == 0 && outcome_q.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Timeout far above the slowest legal run, store clear included.
  initial begin
    #5000000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
